// ===== rtl/pcsh_pkg.sv =====
// Shared constants, types and helper functions for the PC sample histogram.
package pcsh_pkg;

  // Default sizing
  localparam int unsigned DEF_TABLE_DEPTH = 256;
  localparam int unsigned DEF_IMAGE_PAGES = 2048;
  localparam int unsigned DEF_PAGE_BITS   = 12;

  // Field widths
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned INDEX_W   = 12;
  localparam int unsigned ADDR_W    = 32;
  localparam int unsigned CLASS_W   = 2;
  localparam int unsigned BUCKET_W  = 12;
  localparam int unsigned COUNT_W   = 64;
  localparam int unsigned CNT_W     = 32;
  localparam int unsigned ENTRIES_W = 9;
  localparam int unsigned WINDOW_W  = 16;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_ENTRIES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_BASE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MATCH_WINDOW  = 2'd2;

  // Register reset values
  localparam logic [ENTRIES_W-1:0] RST_TABLE_ENTRIES = '0;
  localparam logic [ADDR_W-1:0]    RST_IMAGE_BASE    = 32'h0040_0000;
  localparam logic [WINDOW_W-1:0]  RST_MATCH_WINDOW  = 16'd4096;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD   = 2'd0,
    KIND_SAMPLE = 2'd1,
    KIND_READ   = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_e;

  typedef enum logic [CLASS_W-1:0] {
    CLASS_FUNC    = 2'd0,
    CLASS_PAGE    = 2'd1,
    CLASS_OUTSIDE = 2'd2,
    CLASS_NONE    = 2'd3
  } class_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SEARCH,
    ST_COMPARE,
    ST_SCAN,
    ST_MISS,
    ST_CNT_RD,
    ST_CNT_WR,
    ST_RD_CNT,
    ST_DONE
  } st_e;

  function automatic logic [CNT_W-1:0] sat_inc32(input logic [CNT_W-1:0] v);
    return (v == '1) ? v : v + CNT_W'(1);
  endfunction

  function automatic logic [COUNT_W-1:0] sat_inc64(input logic [COUNT_W-1:0] v);
    return (v == '1) ? v : v + COUNT_W'(1);
  endfunction

endpackage

// ===== rtl/pcsh_if.sv =====
// Valid/ready channel interfaces for sample input beats and result beats.
interface pcsh_in_if;
  logic                          valid;
  logic                          ready;
  logic [pcsh_pkg::KIND_W-1:0]   kind;
  logic [pcsh_pkg::INDEX_W-1:0]  index;
  logic [pcsh_pkg::ADDR_W-1:0]   address;

  modport source (output valid, kind, index, address, input ready);
  modport sink   (input valid, kind, index, address, output ready);
endinterface

interface pcsh_out_if;
  logic                          valid;
  logic                          ready;
  logic [pcsh_pkg::CLASS_W-1:0]  sample_class;
  logic [pcsh_pkg::BUCKET_W-1:0] bucket;
  logic [pcsh_pkg::COUNT_W-1:0]  count_value;

  modport source (output valid, sample_class, bucket, count_value, input ready);
  modport sink   (input valid, sample_class, bucket, count_value, output ready);
endinterface

// ===== rtl/pc_sample_histogram.sv =====
// PC sample histogram: binary-search function match plus page/outside/total counters.
// Beats: load writes the start table, read fetches a counter, clear sweeps every counter slot.
// Sample: S search steps (at most ceil(log2(n+1)), 9 at n=256), then a function hit scans for B,
//   the slot of the first start equal to the match; a miss goes to the page/outside check.
// Throughput: one beat at a time; the single start-table read port sets the search time.
// Reset: async active low; a default sweep over all counter slots zeroes the counters, ready low until done.
module pc_sample_histogram #(
  parameter int unsigned TABLE_DEPTH = pcsh_pkg::DEF_TABLE_DEPTH,
  parameter int unsigned IMAGE_PAGES = pcsh_pkg::DEF_IMAGE_PAGES,
  parameter int unsigned PAGE_BITS   = pcsh_pkg::DEF_PAGE_BITS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  pcsh_in_if.sink                           in_ch,
  pcsh_out_if.source                        out_ch,
  input  logic                              cfg_we_i,
  input  logic [pcsh_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [pcsh_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);

  localparam int unsigned IW     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW     = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned PW     = (IMAGE_PAGES > 1) ? $clog2(IMAGE_PAGES) : 1;
  localparam int unsigned MAXD   = (TABLE_DEPTH > IMAGE_PAGES) ? TABLE_DEPTH : IMAGE_PAGES;
  localparam int unsigned SW     = (MAXD > 1) ? $clog2(MAXD) : 1;
  localparam int unsigned AW     = pcsh_pkg::ADDR_W;
  localparam int unsigned NW     = pcsh_pkg::CNT_W;
  localparam int unsigned VW     = pcsh_pkg::COUNT_W;
  localparam int unsigned BKT_W  = pcsh_pkg::BUCKET_W;
  localparam int unsigned BKT_OUT = TABLE_DEPTH + IMAGE_PAGES;
  localparam int unsigned BKT_TOT = TABLE_DEPTH + IMAGE_PAGES + 1;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [pcsh_pkg::ENTRIES_W-1:0] entries_q;
  logic [AW-1:0]                  base_q;
  logic [pcsh_pkg::WINDOW_W-1:0]  window_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entries_q <= pcsh_pkg::RST_TABLE_ENTRIES;
      base_q    <= pcsh_pkg::RST_IMAGE_BASE;
      window_q  <= pcsh_pkg::RST_MATCH_WINDOW;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pcsh_pkg::CFG_TABLE_ENTRIES: entries_q <= cfg_wdata_i[pcsh_pkg::ENTRIES_W-1:0];
        pcsh_pkg::CFG_IMAGE_BASE:    base_q    <= cfg_wdata_i[AW-1:0];
        pcsh_pkg::CFG_MATCH_WINDOW:  window_q  <= cfg_wdata_i[pcsh_pkg::WINDOW_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  pcsh_pkg::st_e    state_q, state_d;
  pcsh_pkg::kind_e  kind_q;
  logic [BKT_W-1:0] idx_q;
  logic [AW-1:0]    addr_q;
  logic [SW-1:0]    clr_q;
  logic [NW-1:0]    outside_q;
  logic [VW-1:0]    total_q;
  logic             out_valid_q;

  // search / scan
  logic [CW-1:0]    lo_q, hp_q;      // hp is the inclusive upper bound plus one
  logic [IW-1:0]    mid_q;
  logic [IW-1:0]    best_q;          // best match, then the counted slot
  logic             best_vld_q;
  logic [AW-1:0]    best_start_q;
  logic [IW-1:0]    scan_addr_q, cmp_idx_q;
  logic             scan_vld_q;
  logic [PW-1:0]    page_q;

  pcsh_pkg::class_e res_class_q;
  logic [BKT_W-1:0] res_bucket_q;

  logic [pcsh_pkg::CLASS_W-1:0] out_class_q;
  logic [BKT_W-1:0]             out_bucket_q;
  logic [VW-1:0]                out_value_q;

  // ---------------------------------------------------------------------------
  // Memories: function starts, function counts, page counts
  // ---------------------------------------------------------------------------
  logic [AW-1:0] st_mem [TABLE_DEPTH];
  logic [NW-1:0] fc_mem [TABLE_DEPTH];
  logic [NW-1:0] pc_mem [IMAGE_PAGES];

  logic          st_we, st_re;
  logic [IW-1:0] st_waddr, st_raddr;
  logic [AW-1:0] st_rdata_q;

  logic          fc_we, fc_re;
  logic [IW-1:0] fc_waddr, fc_raddr;
  logic [NW-1:0] fc_wdata, fc_rdata_q;

  logic          pc_we, pc_re;
  logic [PW-1:0] pc_waddr, pc_raddr;
  logic [NW-1:0] pc_wdata, pc_rdata_q;

  always_ff @(posedge clk_i) begin
    if (st_we) st_mem[st_waddr] <= in_ch.address;
    if (st_re) st_rdata_q <= st_mem[st_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (fc_we) fc_mem[fc_waddr] <= fc_wdata;
    if (fc_re) fc_rdata_q <= fc_mem[fc_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (pc_we) pc_mem[pc_waddr] <= pc_wdata;
    if (pc_re) pc_rdata_q <= pc_mem[pc_raddr];
  end

  // ---------------------------------------------------------------------------
  // Shared datapath terms
  // ---------------------------------------------------------------------------
  logic           in_ready, in_acc, out_load;
  logic [CW-1:0]  n_eff;
  logic [CW:0]    mid_sum;
  logic [IW-1:0]  mid_w;
  logic           search_go;
  logic [AW-1:0]  fn_dist;
  logic           fn_hit;
  logic           scan_hit;
  logic [AW:0]    pg_diff;
  logic [AW-PAGE_BITS-1:0] pg_full;
  logic           pg_inside;
  logic [31:0]    idx32;
  logic [VW-1:0]  rd_value;

  assign in_acc  = in_ch.valid && in_ready;
  // table_entries beyond the table depth acts as the depth
  assign n_eff   = (32'(entries_q) > TABLE_DEPTH) ? CW'(TABLE_DEPTH) : CW'(entries_q);

  // midpoint of the inclusive range [lo, hp-1]; lo < hp keeps the sum non-negative
  assign mid_sum   = {1'b0, lo_q} + {1'b0, hp_q} - (CW+1)'(1);
  assign mid_w     = mid_sum[IW:1];
  assign search_go = (lo_q < hp_q);

  assign fn_dist  = addr_q - best_start_q;
  assign fn_hit   = best_vld_q && (fn_dist <= AW'(window_q));
  assign scan_hit = scan_vld_q && (st_rdata_q == best_start_q);

  assign pg_diff   = {1'b0, addr_q} - {1'b0, base_q};
  assign pg_full   = pg_diff[AW-1:PAGE_BITS];
  assign pg_inside = !pg_diff[AW] && (32'(pg_full) < IMAGE_PAGES);

  assign idx32 = 32'(idx_q);

  always_comb begin
    if (idx32 < TABLE_DEPTH)       rd_value = VW'(fc_rdata_q);
    else if (idx32 < BKT_OUT)      rd_value = VW'(pc_rdata_q);
    else if (idx32 == BKT_OUT)     rd_value = VW'(outside_q);
    else if (idx32 == BKT_TOT)     rd_value = total_q;
    else                           rd_value = '0;
  end

  // ---------------------------------------------------------------------------
  // Sequencer: next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      pcsh_pkg::ST_CLEAR: begin
        if (clr_q == SW'(MAXD - 1)) begin
          state_d = (kind_q == pcsh_pkg::KIND_CLEAR) ? pcsh_pkg::ST_DONE : pcsh_pkg::ST_IDLE;
        end
      end
      pcsh_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (pcsh_pkg::kind_e'(in_ch.kind))
            pcsh_pkg::KIND_LOAD:   state_d = pcsh_pkg::ST_DONE;
            pcsh_pkg::KIND_SAMPLE: state_d = pcsh_pkg::ST_SEARCH;
            pcsh_pkg::KIND_READ:   state_d = pcsh_pkg::ST_RD_CNT;
            pcsh_pkg::KIND_CLEAR:  state_d = pcsh_pkg::ST_CLEAR;
            default:               state_d = pcsh_pkg::ST_IDLE;
          endcase
        end
      end
      pcsh_pkg::ST_SEARCH: begin
        if (search_go)   state_d = pcsh_pkg::ST_COMPARE;
        else if (fn_hit) state_d = pcsh_pkg::ST_SCAN;
        else             state_d = pcsh_pkg::ST_MISS;
      end
      pcsh_pkg::ST_COMPARE: state_d = pcsh_pkg::ST_SEARCH;
      pcsh_pkg::ST_SCAN: begin
        if (scan_hit) state_d = pcsh_pkg::ST_CNT_RD;
      end
      pcsh_pkg::ST_MISS: begin
        state_d = pg_inside ? pcsh_pkg::ST_CNT_RD : pcsh_pkg::ST_DONE;
      end
      pcsh_pkg::ST_CNT_RD: state_d = pcsh_pkg::ST_CNT_WR;
      pcsh_pkg::ST_CNT_WR: state_d = pcsh_pkg::ST_DONE;
      pcsh_pkg::ST_RD_CNT: state_d = pcsh_pkg::ST_DONE;
      pcsh_pkg::ST_DONE: begin
        if (out_load) state_d = pcsh_pkg::ST_IDLE;
      end
      default: state_d = pcsh_pkg::ST_CLEAR;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer: memory controls and handshake
  // ---------------------------------------------------------------------------
  always_comb begin
    in_ready = 1'b0;
    out_load = 1'b0;
    st_we    = 1'b0;
    st_waddr = IW'(in_ch.index);
    st_re    = 1'b0;
    st_raddr = mid_w;
    fc_we    = 1'b0;
    fc_waddr = best_q;
    fc_wdata = pcsh_pkg::sat_inc32(fc_rdata_q);
    fc_re    = 1'b0;
    fc_raddr = best_q;
    pc_we    = 1'b0;
    pc_waddr = page_q;
    pc_wdata = pcsh_pkg::sat_inc32(pc_rdata_q);
    pc_re    = 1'b0;
    pc_raddr = page_q;
    case (state_q)
      pcsh_pkg::ST_CLEAR: begin
        fc_we    = (32'(clr_q) < TABLE_DEPTH);
        fc_waddr = IW'(clr_q);
        fc_wdata = '0;
        pc_we    = (32'(clr_q) < IMAGE_PAGES);
        pc_waddr = PW'(clr_q);
        pc_wdata = '0;
      end
      pcsh_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        // loads go straight into the start table; slots past the depth are dropped
        st_we    = in_ch.valid && (pcsh_pkg::kind_e'(in_ch.kind) == pcsh_pkg::KIND_LOAD) &&
                   (32'(in_ch.index) < TABLE_DEPTH);
      end
      pcsh_pkg::ST_SEARCH: begin
        st_re = search_go;
      end
      pcsh_pkg::ST_SCAN: begin
        st_re    = 1'b1;
        st_raddr = scan_addr_q;
      end
      pcsh_pkg::ST_CNT_RD: begin
        fc_re = (res_class_q == pcsh_pkg::CLASS_FUNC);
        pc_re = (res_class_q == pcsh_pkg::CLASS_PAGE);
      end
      pcsh_pkg::ST_CNT_WR: begin
        fc_we = (res_class_q == pcsh_pkg::CLASS_FUNC);
        pc_we = (res_class_q == pcsh_pkg::CLASS_PAGE);
      end
      pcsh_pkg::ST_RD_CNT: begin
        fc_re    = 1'b1;
        fc_raddr = IW'(idx_q);
        pc_re    = 1'b1;
        pc_raddr = PW'(idx32 - TABLE_DEPTH);
      end
      pcsh_pkg::ST_DONE: begin
        out_load = !out_valid_q || out_ch.ready;
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Control registers and counters
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pcsh_pkg::ST_CLEAR;
      kind_q      <= pcsh_pkg::KIND_LOAD;
      clr_q       <= '0;
      outside_q   <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load)                          out_valid_q <= 1'b1;
      else if (out_ch.ready)                 out_valid_q <= 1'b0;
      case (state_q)
        pcsh_pkg::ST_CLEAR: clr_q <= clr_q + SW'(1);
        pcsh_pkg::ST_IDLE: begin
          if (in_acc) begin
            kind_q <= pcsh_pkg::kind_e'(in_ch.kind);
            if (pcsh_pkg::kind_e'(in_ch.kind) == pcsh_pkg::KIND_SAMPLE) begin
              total_q <= pcsh_pkg::sat_inc64(total_q);
            end
            if (pcsh_pkg::kind_e'(in_ch.kind) == pcsh_pkg::KIND_CLEAR) begin
              clr_q     <= '0;
              outside_q <= '0;
              total_q   <= '0;
            end
          end
        end
        pcsh_pkg::ST_MISS: begin
          if (!pg_inside) outside_q <= pcsh_pkg::sat_inc32(outside_q);
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Payload registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    case (state_q)
      pcsh_pkg::ST_IDLE: begin
        idx_q        <= in_ch.index;
        addr_q       <= in_ch.address;
        lo_q         <= '0;
        hp_q         <= n_eff;
        best_vld_q   <= 1'b0;
        res_class_q  <= pcsh_pkg::CLASS_NONE;
        res_bucket_q <= (pcsh_pkg::kind_e'(in_ch.kind) == pcsh_pkg::KIND_READ) ?
                        in_ch.index : '0;
      end
      pcsh_pkg::ST_SEARCH: begin
        mid_q       <= mid_w;
        scan_addr_q <= '0;
        scan_vld_q  <= 1'b0;
      end
      pcsh_pkg::ST_COMPARE: begin
        if (st_rdata_q <= addr_q) begin
          best_q       <= mid_q;
          best_start_q <= st_rdata_q;
          best_vld_q   <= 1'b1;
          lo_q         <= CW'(mid_q) + CW'(1);
        end else begin
          hp_q <= CW'(mid_q);
        end
      end
      pcsh_pkg::ST_SCAN: begin
        // one read per cycle; data compares in the cycle after its address
        scan_addr_q <= scan_addr_q + IW'(1);
        cmp_idx_q   <= scan_addr_q;
        scan_vld_q  <= 1'b1;
        if (scan_hit) begin
          best_q       <= cmp_idx_q;
          res_class_q  <= pcsh_pkg::CLASS_FUNC;
          res_bucket_q <= BKT_W'(cmp_idx_q);
        end
      end
      pcsh_pkg::ST_MISS: begin
        page_q <= PW'(pg_full);
        if (pg_inside) begin
          res_class_q  <= pcsh_pkg::CLASS_PAGE;
          res_bucket_q <= BKT_W'(TABLE_DEPTH + 32'(pg_full));
        end else begin
          res_class_q  <= pcsh_pkg::CLASS_OUTSIDE;
          res_bucket_q <= BKT_W'(BKT_OUT);
        end
      end
      pcsh_pkg::ST_DONE: begin
        if (out_load) begin
          out_class_q  <= res_class_q;
          out_bucket_q <= res_bucket_q;
          out_value_q  <= (kind_q == pcsh_pkg::KIND_READ) ? rd_value : '0;
        end
      end
      default: ;
    endcase
  end

  assign in_ch.ready         = in_ready;
  assign out_ch.valid        = out_valid_q;
  assign out_ch.sample_class = out_class_q;
  assign out_ch.bucket       = out_bucket_q;
  assign out_ch.count_value  = out_value_q;

endmodule

// ===== rtl/pcsh_chk.sv =====
// Port-level checker for the PC sample histogram and its bind.
module pcsh_chk (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [pcsh_pkg::CLASS_W-1:0]  out_class,
  input logic [pcsh_pkg::BUCKET_W-1:0] out_bucket,
  input logic [pcsh_pkg::COUNT_W-1:0]  out_value
);

  // one beat in flight: ready drops right after an accepted beat
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a beat is still in work");

  // only reads carry a count value
  a_value_on_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && (out_class != pcsh_pkg::CLASS_NONE) |-> (out_value == '0))
    else $error("sample result carries a nonzero count value");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=>
      $stable(out_class) && $stable(out_bucket) && $stable(out_value))
    else $error("result payload changed while stalled");

endmodule

bind pc_sample_histogram pcsh_chk u_pcsh_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_class  (out_ch.sample_class),
  .out_bucket (out_ch.bucket),
  .out_value  (out_ch.count_value)
);

// ===== verif/tb.sv =====
// Self-checking testbench for the PC sample histogram: directed and random beats.
module tb;
  import pcsh_pkg::*;

  localparam int unsigned TBL       = DEF_TABLE_DEPTH;
  localparam int unsigned PAGES     = DEF_IMAGE_PAGES;
  localparam int unsigned PG_SHIFT  = DEF_PAGE_BITS;
  localparam int unsigned OUT_BKT   = TBL + PAGES;
  localparam int unsigned TOTAL_BKT = TBL + PAGES + 1;
  // Slowest beats are a function hit whose scan runs to a high slot, and a clear.
  // A few hundred beats plus a handful of clears stay well under this.
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned MAX_IDLE    = 14;

  typedef struct packed {
    kind_e             kind;
    logic [INDEX_W-1:0] index;
    logic [ADDR_W-1:0]  address;
  } cmd_t;

  typedef struct packed {
    class_e              cls;
    logic [BUCKET_W-1:0] bucket;
    logic [COUNT_W-1:0]  count;
  } res_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx   = CFG_TABLE_ENTRIES;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  pcsh_in_if  in_ch ();
  pcsh_out_if out_ch ();

  pc_sample_histogram u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Histogram predictor: its own copy of the table, counters and registers.
  // ---------------------------------------------------------------------------
  logic [31:0]           fn_start  [TBL];
  logic [31:0]           fn_hits   [TBL];
  logic [31:0]           page_hits [PAGES];
  logic [31:0]           outside_hits;
  logic [63:0]           sample_total;
  logic [ENTRIES_W-1:0]  model_entries;
  logic [ADDR_W-1:0]     model_base;
  logic [WINDOW_W-1:0]   model_window;

  // Stimulus-side view of the table, updated as beats are queued.  Registers
  // only change while idle, so this always matches what the predictor sees.
  logic [31:0]           gen_start   [TBL];
  bit                    slot_loaded [TBL];
  logic [31:0]           last_pc;

  cmd_t        cmd_q[$];       // beats waiting to be driven
  res_t        due_results[$]; // predicted results, oldest first
  cmd_t        cur_cmd;
  bit          feeding;
  int unsigned gap_left;
  int unsigned stall_left;
  bit          in_calm;
  bit          out_calm;
  int unsigned errors;
  int unsigned cycles;

  function automatic logic [31:0] bump32(input logic [31:0] v);
    return (v == '1) ? v : v + 32'd1;
  endfunction

  function automatic void zero_counters();
    for (int unsigned i = 0; i < TBL; i++) fn_hits[i] = '0;
    for (int unsigned i = 0; i < PAGES; i++) page_hits[i] = '0;
    outside_hits = '0;
    sample_total = '0;
  endfunction

  // Apply one accepted beat to the predictor state and return its result.
  function automatic res_t histogram_apply(input cmd_t c);
    res_t        r;
    int          n, lo, hi, mid, best, hit, b;
    logic [31:0] pg;
    r.cls    = CLASS_NONE;
    r.bucket = '0;
    r.count  = '0;
    case (c.kind)
      KIND_LOAD: begin
        if (c.index < TBL) fn_start[c.index] = c.address;
      end
      KIND_SAMPLE: begin
        if (sample_total != '1) sample_total = sample_total + 64'd1;
        n    = (model_entries > TBL) ? TBL : int'(model_entries);
        lo   = 0;
        hi   = n - 1;
        best = -1;
        hit  = -1;
        // greatest start at or below the pc
        while (lo <= hi) begin
          mid = (lo + hi) / 2;
          if (fn_start[mid] <= c.address) begin
            best = mid;
            lo   = mid + 1;
          end else begin
            hi = mid - 1;
          end
        end
        if (best >= 0 && (c.address - fn_start[best]) <= {16'h0, model_window}) begin
          // duplicates: credit the lowest slot holding the same start
          hit = best;
          for (b = best; b >= 0; b--)
            if (fn_start[b] == fn_start[best]) hit = b;
        end
        if (hit >= 0) begin
          fn_hits[hit] = bump32(fn_hits[hit]);
          r.cls        = CLASS_FUNC;
          r.bucket     = BUCKET_W'(hit);
        end else begin
          pg = (c.address - model_base) >> PG_SHIFT;
          if (c.address >= model_base && pg < PAGES) begin
            page_hits[pg] = bump32(page_hits[pg]);
            r.cls         = CLASS_PAGE;
            r.bucket      = BUCKET_W'(TBL + pg);
          end else begin
            outside_hits = bump32(outside_hits);
            r.cls        = CLASS_OUTSIDE;
            r.bucket     = BUCKET_W'(OUT_BKT);
          end
        end
      end
      KIND_READ: begin
        r.bucket = c.index;
        if (c.index < TBL)            r.count = {32'h0, fn_hits[c.index]};
        else if (c.index < OUT_BKT)   r.count = {32'h0, page_hits[c.index - TBL]};
        else if (c.index == OUT_BKT)  r.count = {32'h0, outside_hits};
        else if (c.index == TOTAL_BKT) r.count = sample_total;
      end
      default: zero_counters();
    endcase
    return r;
  endfunction

  task automatic note_mismatch(input string msg);
    errors++;
    $display("tb: mismatch at cycle %0d: %s", cycles, msg);
  endtask

  // ---------------------------------------------------------------------------
  // Input driver: pops queued beats, inserts random idle gaps between them,
  // with occasional calm stretches where beats go back to back.
  // ---------------------------------------------------------------------------
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_ch.valid   <= 1'b0;
      in_ch.kind    <= KIND_LOAD;
      in_ch.index   <= '0;
      in_ch.address <= '0;
      feeding       = 1'b0;
      gap_left      = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        due_results.push_back(histogram_apply(cur_cmd));
        feeding = 1'b0;
        if ($urandom_range(0, 39) == 0) in_calm = !in_calm;
        gap_left = in_calm ? 0 : $urandom_range(0, MAX_IDLE);
      end
      if (!feeding) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (cmd_q.size() != 0) begin
          cur_cmd = cmd_q.pop_front();
          feeding = 1'b1;
        end
      end
      in_ch.valid   <= feeding;
      in_ch.kind    <= cur_cmd.kind;
      in_ch.index   <= cur_cmd.index;
      in_ch.address <= cur_cmd.address;
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: checks each beat against the oldest prediction and,
  // outside calm stretches, stalls ready for a random while after each beat.
  // ---------------------------------------------------------------------------
  always @(posedge clk or negedge rst_n) begin
    res_t exp_r;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left   = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (due_results.size() == 0) begin
          note_mismatch($sformatf("unexpected result class %0d bucket %0d",
                                  out_ch.sample_class, out_ch.bucket));
        end else begin
          exp_r = due_results.pop_front();
          if (out_ch.sample_class !== exp_r.cls)
            note_mismatch($sformatf("sample_class %0d, want %0d",
                                    out_ch.sample_class, exp_r.cls));
          if (out_ch.bucket !== exp_r.bucket)
            note_mismatch($sformatf("bucket %0d, want %0d", out_ch.bucket, exp_r.bucket));
          if (out_ch.count_value !== exp_r.count)
            note_mismatch($sformatf("count_value %0h, want %0h (bucket %0d)",
                                    out_ch.count_value, exp_r.count, exp_r.bucket));
        end
        if ($urandom_range(0, 39) == 0) out_calm = !out_calm;
        stall_left = out_calm ? 0 : $urandom_range(0, MAX_IDLE);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_cmd(input kind_e k, input logic [INDEX_W-1:0] idx,
                          input logic [ADDR_W-1:0] a);
    cmd_q.push_back('{k, idx, a});
    if (k == KIND_LOAD && idx < TBL) begin
      gen_start[idx]   = a;
      slot_loaded[idx] = 1'b1;
    end
    if (k == KIND_SAMPLE) last_pc = a;
  endtask

  // Block until every queued beat is accepted and every result is back.
  task automatic wait_idle();
    while (cmd_q.size() != 0 || feeding || due_results.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= d;
    case (idx)
      CFG_TABLE_ENTRIES: model_entries = d[ENTRIES_W-1:0];
      CFG_IMAGE_BASE:    model_base    = d;
      CFG_MATCH_WINDOW:  model_window  = d[WINDOW_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // One random beat.  Most are samples aimed at table starts and window edges
  // or at the image, the rest are reads, stray loads, wild pcs and clears.
  task automatic random_item();
    int unsigned       pick, n, slot;
    logic [ADDR_W-1:0] a;
    logic [INDEX_W-1:0] idx;
    n    = (model_entries > TBL) ? TBL : model_entries;
    pick = $urandom_range(0, 99);
    if (pick < 55 && n > 0) begin
      slot = $urandom_range(0, n - 1);
      case ($urandom_range(0, 4))
        0:       a = gen_start[slot];
        1:       a = gen_start[slot] + model_window;
        2:       a = gen_start[slot] + model_window + 32'd1;
        3:       a = gen_start[slot] - 32'd1;
        default: a = gen_start[slot] + $urandom_range(0, model_window);
      endcase
      push_cmd(KIND_SAMPLE, INDEX_W'($urandom), a);
    end else if (pick < 75) begin
      // around the image, spilling a little past either end
      a = model_base + $urandom_range(0, 32'h0080_1000) - 32'h800;
      push_cmd(KIND_SAMPLE, INDEX_W'($urandom), a);
    end else if (pick < 82) begin
      push_cmd(KIND_SAMPLE, INDEX_W'($urandom), $urandom);
    end else if (pick < 94) begin
      case ($urandom_range(0, 3))
        0:       idx = INDEX_W'($urandom_range(0, (n > 0) ? n - 1 : 0));
        1:       idx = INDEX_W'(TBL + ((last_pc - model_base) >> PG_SHIFT));
        2:       idx = INDEX_W'(OUT_BKT + $urandom_range(0, 1));
        default: idx = INDEX_W'($urandom);
      endcase
      push_cmd(KIND_READ, idx, $urandom);
    end else if (pick < 98) begin
      // stray load: may break the sort order or land past the table
      idx = ($urandom_range(0, 3) == 0) ? INDEX_W'($urandom_range(TBL, 4095))
                                        : INDEX_W'($urandom_range(0, TBL - 1));
      a = ($urandom_range(0, 1) == 0) ? $urandom
                                      : gen_start[idx[7:0]] + $urandom_range(0, 32'h2000);
      push_cmd(KIND_LOAD, idx, a);
    end else begin
      push_cmd(KIND_CLEAR, INDEX_W'($urandom), $urandom);
    end
  endtask

  // Reprogram the registers once idle, then queue random beats.  With a partly
  // loaded table the entry count is capped at the loaded prefix so no search
  // touches an empty slot; a full table also takes counts past its depth.
  task automatic run_phase(input int unsigned entries, input logic [ADDR_W-1:0] base,
                           input logic [WINDOW_W-1:0] window, input int unsigned beats);
    int unsigned lim;
    lim = 0;
    while (lim < TBL && slot_loaded[lim]) lim++;
    if (lim < TBL && entries > lim) entries = lim;
    wait_idle();
    // upper bits of the data word are don't-care for the narrow registers
    cfg_write(CFG_TABLE_ENTRIES, {23'($urandom), ENTRIES_W'(entries)});
    cfg_write(CFG_IMAGE_BASE, base);
    cfg_write(CFG_MATCH_WINDOW, {16'($urandom), window});
    for (int unsigned k = 0; k < beats; k++) random_item();
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [ADDR_W-1:0] a;
    for (int unsigned i = 0; i < TBL; i++) begin
      fn_start[i]    = '0;
      gen_start[i]   = '0;
      slot_loaded[i] = 1'b0;
    end
    zero_counters();
    model_entries = RST_TABLE_ENTRIES;
    model_base    = RST_IMAGE_BASE;
    model_window  = RST_MATCH_WINDOW;
    last_pc       = '0;
    errors        = 0;
    cycles        = 0;
    in_calm       = 1'b0;
    out_calm      = 1'b0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Reset registers, empty table: everything lands in pages or outside.
    push_cmd(KIND_SAMPLE, '0, 32'h0000_0000);   // address zero, below image
    push_cmd(KIND_SAMPLE, '0, 32'h0040_0000);   // first byte of page 0
    push_cmd(KIND_SAMPLE, '0, 32'h00BF_FFFF);   // last byte of the last page
    push_cmd(KIND_SAMPLE, '0, 32'h00C0_0000);   // one past the image
    push_cmd(KIND_SAMPLE, 12'hFFF, 32'hFFFF_FFFF);
    push_cmd(KIND_READ, 12'(TBL + PAGES - 1), '0);
    push_cmd(KIND_READ, 12'(OUT_BKT), '0);
    push_cmd(KIND_READ, 12'(TOTAL_BKT), '0);
    push_cmd(KIND_READ, 12'hFFF, '0);           // unused counter number
    push_cmd(KIND_LOAD, 12'hFFF, 32'h1234_5678); // slot past the table, dropped
    // ascending table with a pair and a triple of equal starts
    push_cmd(KIND_LOAD, 12'd0, 32'h0000_0010);
    push_cmd(KIND_LOAD, 12'd1, 32'h0040_1000);
    push_cmd(KIND_LOAD, 12'd2, 32'h0040_1000);
    push_cmd(KIND_LOAD, 12'd3, 32'h0050_0000);
    push_cmd(KIND_LOAD, 12'd4, 32'h0050_0000);
    push_cmd(KIND_LOAD, 12'd5, 32'h0050_0000);
    push_cmd(KIND_LOAD, 12'd6, 32'h00A0_0000);
    push_cmd(KIND_LOAD, 12'd7, 32'hFFFF_FFFF);
    push_cmd(KIND_CLEAR, '0, '0);

    // Eight slots, zero window: only exact starts count as functions.
    run_phase(8, 32'h0040_0000, 16'd0, 0);
    push_cmd(KIND_SAMPLE, '0, 32'h0000_0010);   // exact hit on slot 0
    push_cmd(KIND_SAMPLE, '0, 32'h0000_0011);   // one past, window 0 -> outside
    push_cmd(KIND_SAMPLE, '0, 32'h0040_1000);   // duplicate start -> slot 1
    push_cmd(KIND_SAMPLE, '0, 32'hFFFF_FFFF);   // top of address space -> slot 7
    push_cmd(KIND_SAMPLE, '0, 32'h0000_000F);   // below the first start

    // Fill all slots in ascending order with random gaps and some repeats,
    // interleaved with traffic against the small table still in use.
    run_phase(8, 32'h0040_0000, 16'd4096, 0);
    a = 32'h0040_0000 + $urandom_range(0, 32'hFFF);
    for (int unsigned s = 0; s < TBL; s++) begin
      push_cmd(KIND_LOAD, INDEX_W'(s), a);
      if ($urandom_range(0, 7) == 0) random_item();
      if ($urandom_range(0, 7) != 0) a = a + $urandom_range(1, 32'h9000);
    end

    // Register extremes, an entry count past the depth and a few random settings.
    run_phase(TBL, 32'h0040_0000, 16'd4096, 20);
    run_phase(511, 32'h0000_0000, 16'hFFFF, 15);
    run_phase(TBL, 32'hFFFF_FFFF, 16'd0, 15);
    run_phase(0, 32'hFFFF_F000, 16'd300, 10);
    repeat (2)
      run_phase($urandom_range(1, TBL), gen_start[$urandom_range(0, TBL - 1)] -
                $urandom_range(0, 32'h20_0000), 16'($urandom), 15);
    run_phase(TBL, gen_start[0], 16'd2048, 20);

    wait_idle();
    // let any stray extra beat show up before judging
    repeat (40) @(posedge clk);
    if (errors == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/pcsh_pkg.sv
rtl/pcsh_if.sv
rtl/pc_sample_histogram.sv
rtl/pcsh_chk.sv
verif/tb.sv
